// ----- rtl/core/buddy_page_allocator_unit_defines.svh -----
// ----------------------------------------------------------------------------
// buddy page allocator assertion macros
// concurrent checks clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef SYNTH
// property checked on every edge outside reset
`define BPA_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("buddy allocator check failed");
// condition in one cycle implies a property in the next
`define BPA_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("buddy allocator sequencing check failed");
`else
`define BPA_ASSERT(label, prop)
`define BPA_ASSERT_NEXT(label, cond, prop)
`endif

`endif

// ----- rtl/core/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpa_pkg
// shared types, constants and helpers of the buddy page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int MAX_ORDER = 10;
  localparam int PAGES     = 1024;
  localparam int NLISTS    = MAX_ORDER + 1;
  localparam int IW        = 10;  // page index width
  localparam int CW        = 11;  // page count width
  localparam int OW        = 4;   // order width

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOBLK = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // request class decided by the front end
  typedef enum logic [1:0] {
    K_ZERO  = 2'd0,
    K_BIG   = 2'd1,
    K_ALLOC = 2'd2,
    K_FREE  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t          kind;
    logic [OW-1:0]  k;
    logic [CW-1:0]  n;
    logic [IW-1:0]  b;
  } req_t;

  typedef struct packed {
    logic [1:0]     status;
    logic [IW-1:0]  where;
    logic [CW-1:0]  free;
  } res_t;

  // per-page block descriptor
  typedef struct packed {
    logic           head;
    logic [OW-1:0]  ord;
  } hd_t;

  function automatic logic [CW-1:0] pow2(logic [OW-1:0] o);
    pow2 = CW'(1) << o;
  endfunction

  // smallest k with 2^k >= n, saturating at 11
  function automatic logic [OW-1:0] ceil_log2(logic [CW-1:0] n);
    logic [OW-1:0] k;
    k = '0;
    for (int i = 0; i < CW; i++) begin
      if ((12'(1) << i) < 12'(n)) k = OW'(i + 1);
    end
    ceil_log2 = k;
  endfunction

endpackage

// ----- rtl/core/bpa_ram.sv -----
// ----------------------------------------------------------------------------
// bpa_ram
// generic single write, single read RAM with registered read data
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/bpa_front.sv -----
// ----------------------------------------------------------------------------
// bpa_front
// accepts requests and classifies them before they enter the queue
// ----------------------------------------------------------------------------
module bpa_front (
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [23:0]           s_tdata,
  input  logic [0:0]            s_tuser,
  input  logic [bpa_pkg::CW-1:0] pool_pages,
  input  logic                  init_busy,
  input  logic                  q_ready,
  output logic                  q_push,
  output bpa_pkg::req_t         q_req
);

  logic [bpa_pkg::CW-1:0] n;
  logic [bpa_pkg::IW-1:0] b;
  logic [bpa_pkg::OW-1:0] k;

  assign n = s_tdata[10:0];
  assign b = s_tdata[20:11];
  assign k = bpa_pkg::ceil_log2(n);

  // no request taken while the pool is being rebuilt
  assign s_tready = q_ready && !init_busy;
  assign q_push   = s_tvalid && s_tready;

  // classify
  always_comb begin
    q_req.k = k;
    q_req.n = n;
    q_req.b = b;
    if (n == '0) begin
      q_req.kind = bpa_pkg::K_ZERO;
    end else if (s_tuser[0] == 1'b0) begin
      q_req.kind = (k > bpa_pkg::OW'(bpa_pkg::MAX_ORDER)) ? bpa_pkg::K_BIG : bpa_pkg::K_ALLOC;
    end else begin
      q_req.kind = ((12'(b) + 12'(n)) > 12'(pool_pages)) ? bpa_pkg::K_BIG : bpa_pkg::K_FREE;
    end
  end

endmodule

// ----- rtl/core/bpa_queue.sv -----
// ----------------------------------------------------------------------------
// bpa_queue
// two-entry request queue between front end and back end
// ----------------------------------------------------------------------------
module bpa_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bpa_pkg::req_t push_req,
  output logic          ready,
  input  logic          pop,
  output logic          valid,
  output bpa_pkg::req_t head
);

  bpa_pkg::req_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign ready = (count != 2'd2);
  assign valid = (count != 2'd0);
  assign head  = entry[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_req;
  end

endmodule

// ----- rtl/core/bpa_back.sv -----
// ----------------------------------------------------------------------------
// bpa_back
// sequencer that carries out requests on the free lists and page tables
// ----------------------------------------------------------------------------
`include "buddy_page_allocator_unit_defines.svh"

module bpa_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   reinit,
  input  logic [bpa_pkg::CW-1:0] pool_pages,
  input  logic                   q_valid,
  input  bpa_pkg::req_t          q_req,
  output logic                   q_pop,
  output logic                   init_busy,
  output logic                   out_valid,
  input  logic                   out_ready,
  output bpa_pkg::res_t          out_res
);

  localparam int MAXO = bpa_pkg::MAX_ORDER;
  localparam int NL   = bpa_pkg::NLISTS;
  localparam int IW   = bpa_pkg::IW;
  localparam int CW   = bpa_pkg::CW;
  localparam int OW   = bpa_pkg::OW;

  typedef enum logic [9:0] {
    S_CLR     = 10'b0000000001,
    S_FILL    = 10'b0000000010,
    S_IDLE    = 10'b0000000100,
    S_A_UNL   = 10'b0000001000,
    S_A_SPLIT = 10'b0000010000,
    S_R_PICK  = 10'b0000100000,
    S_M_RD    = 10'b0001000000,
    S_M_CHK   = 10'b0010000000,
    S_SCAN    = 10'b0100000000,
    S_DONE    = 10'b1000000000
  } state_t;

  state_t state;

  logic [CW-1:0] cnt    [NL];
  logic [IW-1:0] lfirst [NL];
  logic [IW-1:0] llast  [NL];
  logic [CW-1:0] free_total;

  bpa_pkg::req_t cur;
  logic [OW-1:0] cur_o;
  logic [IW-1:0] a_page;
  logic [CW-1:0] rel_idx;
  logic [CW-1:0] rel_n;
  logic [IW-1:0] mrg_idx;
  logic [OW-1:0] mrg_o;
  logic [CW-1:0] scan_p;
  logic [IW-1:0] scan_pd;
  logic          rd_v;
  logic [1:0]    res_status;
  logic [IW-1:0] res_where;
  logic [CW-1:0] clr_a;
  logic [CW-1:0] fill_p;
  logic [CW-1:0] fill_rem;
  logic [OW-1:0] fill_o;

  // ram ports
  logic          hd_we, nx_we, pv_we;
  logic [IW-1:0] hd_wa, nx_wa, pv_wa, raddr;
  bpa_pkg::hd_t  hd_wd, hd_q;
  logic [IW-1:0] nx_wd, pv_wd, nx_q, pv_q;

  // list operations of this cycle
  logic          do_app, do_unl;
  logic [OW-1:0] app_o, unl_o;
  logic [IW-1:0] app_p, unl_p;

  logic          found;
  logic [OW-1:0] fo;
  logic [OW-1:0] o_pick;
  logic [IW-1:0] pair;
  logic          pair_in;
  logic          match;
  logic [CW-1:0] scan_end;
  logic          clash;

  assign init_busy = (state == S_CLR) || (state == S_FILL);
  assign q_pop     = (state == S_IDLE) && q_valid && !out_valid;

  // smallest non-empty list at or above the requested order
  always_comb begin
    found = 1'b0;
    fo    = '0;
    for (int i = MAXO; i >= 0; i--) begin
      if ((OW'(i) >= q_req.k) && (cnt[i] != '0)) begin
        found = 1'b1;
        fo    = OW'(i);
      end
    end
  end

  // largest aligned block that fits the rest of the range
  always_comb begin
    o_pick = '0;
    for (int i = 0; i <= MAXO; i++) begin
      if (((rel_idx & ((CW'(1) << i) - CW'(1))) == '0) && (bpa_pkg::pow2(OW'(i)) <= rel_n))
        o_pick = OW'(i);
    end
  end

  assign pair     = mrg_idx ^ (IW'(1) << mrg_o);
  assign pair_in  = (CW'(pair) < pool_pages);
  assign match    = hd_q.head && (hd_q.ord == mrg_o);
  assign scan_end = CW'(cur.b) + cur.n;
  assign clash    = rd_v && hd_q.head &&
                    (12'(cur.b) < (12'(scan_pd) + (12'(1) << hd_q.ord)));

  // list operation select and read address
  always_comb begin
    do_app = 1'b0;
    do_unl = 1'b0;
    app_o  = mrg_o;
    app_p  = mrg_idx;
    unl_o  = mrg_o;
    unl_p  = pair;
    raddr  = pair;
    case (state)
      S_FILL: begin
        app_o = fill_o;
        app_p = fill_p[IW-1:0];
        do_app = (fill_rem >= bpa_pkg::pow2(fill_o));
      end
      S_IDLE: begin
        raddr = lfirst[fo];
      end
      S_A_UNL: begin
        do_unl = 1'b1;
        unl_o  = cur_o;
        unl_p  = a_page;
      end
      S_A_SPLIT: begin
        app_o  = cur_o - OW'(1);
        app_p  = a_page + (IW'(1) << (cur_o - OW'(1)));
        do_app = (cur_o > cur.k);
      end
      S_M_RD: begin
        do_app = !((mrg_o < OW'(MAXO)) && pair_in);
      end
      S_M_CHK: begin
        do_unl = match;
        do_app = !match;
      end
      S_SCAN: begin
        raddr = scan_p[IW-1:0];
      end
      default: ;
    endcase
  end

  // ram write ports
  always_comb begin
    hd_we = 1'b0;
    hd_wa = app_p;
    hd_wd = '0;
    nx_we = 1'b0;
    nx_wa = llast[app_o];
    nx_wd = app_p;
    pv_we = 1'b0;
    pv_wa = app_p;
    pv_wd = llast[app_o];
    if (state == S_CLR) begin
      hd_we = (clr_a < pool_pages);
      hd_wa = clr_a[IW-1:0];
    end else if (do_app) begin
      hd_we = 1'b1;
      hd_wd = '{head: 1'b1, ord: app_o};
      nx_we = (cnt[app_o] != '0);
      pv_we = (cnt[app_o] != '0);
    end else if (do_unl) begin
      hd_we = 1'b1;
      hd_wa = unl_p;
      nx_wa = pv_q;
      nx_wd = nx_q;
      pv_wa = nx_q;
      pv_wd = pv_q;
      if ((cnt[unl_o] > CW'(1)) && (lfirst[unl_o] != unl_p) && (llast[unl_o] != unl_p)) begin
        nx_we = 1'b1;
        pv_we = 1'b1;
      end
    end
  end

  bpa_ram #(.W($bits(bpa_pkg::hd_t)), .D(bpa_pkg::PAGES)) u_hd (
    .clk(clk), .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(raddr), .rdata(hd_q)
  );
  bpa_ram #(.W(IW), .D(bpa_pkg::PAGES)) u_nx (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(raddr), .rdata(nx_q)
  );
  bpa_ram #(.W(IW), .D(bpa_pkg::PAGES)) u_pv (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(raddr), .rdata(pv_q)
  );

  // free list heads, tails, counts and free page total
  always_ff @(posedge clk) begin
    if (rst || reinit) begin
      for (int i = 0; i < NL; i++) begin
        cnt[i]    <= '0;
        lfirst[i] <= '0;
        llast[i]  <= '0;
      end
      free_total <= '0;
    end else if (do_app) begin
      if (cnt[app_o] == '0) lfirst[app_o] <= app_p;
      llast[app_o] <= app_p;
      cnt[app_o]   <= cnt[app_o] + CW'(1);
      free_total   <= free_total + bpa_pkg::pow2(app_o);
    end else if (do_unl) begin
      if (cnt[unl_o] <= CW'(1)) begin
        cnt[unl_o] <= '0;
      end else begin
        if (lfirst[unl_o] == unl_p) lfirst[unl_o] <= nx_q;
        else if (llast[unl_o] == unl_p) llast[unl_o] <= pv_q;
        cnt[unl_o] <= cnt[unl_o] - CW'(1);
      end
      free_total <= free_total - bpa_pkg::pow2(unl_o);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst || reinit) begin
      state     <= S_CLR;
      clr_a     <= '0;
      out_valid <= 1'b0;
      rd_v      <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_CLR: begin
          if (clr_a < pool_pages) begin
            clr_a <= clr_a + CW'(1);
          end else begin
            fill_p   <= '0;
            fill_rem <= pool_pages;
            fill_o   <= OW'(MAXO);
            state    <= S_FILL;
          end
        end
        S_FILL: begin
          if (fill_rem >= bpa_pkg::pow2(fill_o)) begin
            fill_p   <= fill_p + bpa_pkg::pow2(fill_o);
            fill_rem <= fill_rem - bpa_pkg::pow2(fill_o);
          end else if (fill_o == '0) begin
            state <= S_IDLE;
          end else begin
            fill_o <= fill_o - OW'(1);
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            cur        <= q_req;
            res_where  <= '0;
            res_status <= bpa_pkg::ST_OK;
            case (q_req.kind)
              bpa_pkg::K_ZERO: begin
                res_status <= bpa_pkg::ST_ZERO;
                state      <= S_DONE;
              end
              bpa_pkg::K_BIG: begin
                res_status <= bpa_pkg::ST_RANGE;
                state      <= S_DONE;
              end
              bpa_pkg::K_ALLOC: begin
                if (found) begin
                  a_page <= lfirst[fo];
                  cur_o  <= fo;
                  state  <= S_A_UNL;
                end else begin
                  res_status <= bpa_pkg::ST_NOBLK;
                  state      <= S_DONE;
                end
              end
              bpa_pkg::K_FREE: begin
                scan_p <= '0;
                rd_v   <= 1'b0;
                state  <= S_SCAN;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_A_UNL: begin
          res_where <= a_page;
          state     <= S_A_SPLIT;
        end
        S_A_SPLIT: begin
          if (cur_o > cur.k) begin
            cur_o <= cur_o - OW'(1);
          end else if (cur.n != bpa_pkg::pow2(cur.k)) begin
            rel_idx <= CW'(a_page) + cur.n;
            rel_n   <= bpa_pkg::pow2(cur.k) - cur.n;
            state   <= S_R_PICK;
          end else begin
            state <= S_DONE;
          end
        end
        S_R_PICK: begin
          if (rel_n == '0) begin
            state <= S_DONE;
          end else begin
            mrg_idx <= rel_idx[IW-1:0];
            mrg_o   <= o_pick;
            rel_idx <= rel_idx + bpa_pkg::pow2(o_pick);
            rel_n   <= rel_n - bpa_pkg::pow2(o_pick);
            state   <= S_M_RD;
          end
        end
        S_M_RD: begin
          state <= ((mrg_o < OW'(MAXO)) && pair_in) ? S_M_CHK : S_R_PICK;
        end
        S_M_CHK: begin
          if (match) begin
            mrg_idx <= mrg_idx & ~(IW'(1) << mrg_o);
            mrg_o   <= mrg_o + OW'(1);
            state   <= S_M_RD;
          end else begin
            state <= S_R_PICK;
          end
        end
        S_SCAN: begin
          if (clash) begin
            res_status <= bpa_pkg::ST_NOBLK;
            rd_v       <= 1'b0;
            state      <= S_DONE;
          end else if (scan_p < scan_end) begin
            scan_pd <= scan_p[IW-1:0];
            scan_p  <= scan_p + CW'(1);
            rd_v    <= 1'b1;
          end else if (rd_v) begin
            rd_v <= 1'b0;
          end else begin
            rel_idx <= CW'(cur.b);
            rel_n   <= cur.n;
            state   <= S_R_PICK;
          end
        end
        S_DONE: begin
          out_valid      <= 1'b1;
          out_res.status <= res_status;
          out_res.where  <= res_where;
          out_res.free   <= free_total;
          state          <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `BPA_ASSERT(a_free_le_pool, reinit || (free_total <= pool_pages))
  `BPA_ASSERT(a_pop_only_idle, q_pop |-> ((state == S_IDLE) && !out_valid))
  `BPA_ASSERT(a_split_order, (state == S_A_SPLIT) |-> (cur_o >= cur.k))
  `BPA_ASSERT(a_merge_order, (state == S_M_CHK) |-> (mrg_o < OW'(MAXO)))
  `BPA_ASSERT_NEXT(a_done_shows, (state == S_DONE) && !reinit, out_valid)

endmodule

// ----- rtl/core/buddy_page_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// buddy_page_allocator_unit
// buddy page allocator with stream request and result channels
// ----------------------------------------------------------------------------
// Requests are classified on entry and queued (two deep); a sequencer then
// works them one at a time against per-page tables held in RAM, and does not
// take the next request while a result is still waiting on the result
// channel. Zero-count and out-of-range requests go straight to a result. An
// allocate unlinks a free block, splits it down to the needed order and, for
// a tail, releases the unused pages as aligned blocks, each merged with its
// free buddies. A free first scans page descriptors from page 0 up to the
// end of the range, one page a cycle, then releases the range as above.
// After reset and after every write of pool_pages a clearing pass and a
// greedy fill run, during which no request is accepted.
module buddy_page_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // page_count[10:0], page_index[20:11], zero pad
  input  logic [0:0]  s_tuser,   // action[0]
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // alloc_index[9:0], free_count[20:10], zero pad
  output logic [1:0]  m_tuser,   // status[1:0]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [bpa_pkg::CW-1:0] pool_pages;
  logic                   cfg_wr;
  logic                   reinit;
  logic                   init_busy;
  logic                   q_ready, q_push, q_valid, q_pop;
  bpa_pkg::req_t          q_in, q_head;
  bpa_pkg::res_t          res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = {21'd0, pool_pages};

  // pool size register, saturated to the table depth
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_pages <= bpa_pkg::CW'(bpa_pkg::PAGES);
      reinit     <= 1'b0;
    end else begin
      reinit <= 1'b0;
      if (cfg_wr) begin
        pool_pages <= (pwdata[10:0] > bpa_pkg::CW'(bpa_pkg::PAGES)) ?
                      bpa_pkg::CW'(bpa_pkg::PAGES) : pwdata[10:0];
        reinit     <= 1'b1;
      end
    end
  end

  bpa_front u_front (
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .pool_pages(pool_pages), .init_busy(init_busy || reinit), .q_ready(q_ready),
    .q_push(q_push), .q_req(q_in)
  );

  bpa_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_req(q_in), .ready(q_ready),
    .pop(q_pop), .valid(q_valid), .head(q_head)
  );

  bpa_back u_back (
    .clk(clk), .rst(rst), .reinit(reinit), .pool_pages(pool_pages),
    .q_valid(q_valid), .q_req(q_head), .q_pop(q_pop), .init_busy(init_busy),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
  );

  // result packing
  assign m_tuser = res.status;
  assign m_tdata = {3'd0, res.free, res.where};

endmodule
